// ===== sv/gsvc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the gas supply valve controller: field widths, register indexes,
// coil bit positions, mode codes and the time window check. It has no dependencies.
package gsvc_pkg;

    localparam int PRESS_W     = 16;
    localparam int TIME_W      = 13;
    localparam int USER_VALVES = 12;
    localparam int COIL_W      = 16;
    localparam int MODE_W      = 2;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 4;

    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] REG_START_RELIEF = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VAP_FEED     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TANK_SUPPL   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_PRESS   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_TANK    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_VAP     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SAFETY       = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_WINDOW  = 4'd7;

    localparam int COIL_GAS    = 0;
    localparam int COIL_LIQUID = 1;
    localparam int COIL_RELIEF = 2;
    localparam int COIL_OUTLET = 3;
    localparam int COIL_USER0  = 4;

    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

    typedef struct packed {
        logic                   heater_too_cold;
        logic                   sensor_error;
        logic [USER_VALVES-1:0] boot_inputs;
        logic [TIME_W-1:0]      time_of_day;
        logic [PRESS_W-1:0]     liquid_level;
        logic [PRESS_W-1:0]     vaporizer_pressure;
        logic [PRESS_W-1:0]     tank_pressure;
    } tick_t;

    // A window whose start lies after its end wraps past midnight.
    function automatic logic in_window(
        input logic [TIME_W-1:0]  now,
        input logic [PRESS_W-1:0] from,
        input logic [PRESS_W-1:0] to
    );
        logic [PRESS_W-1:0] now_w;
        logic               ok;
        begin
            now_w = PRESS_W'(now);
            if (from == to)
            begin
                ok = 1'b1;
            end
            else if (from < to)
            begin
                ok = (now_w >= from) && (now_w <= to);
            end
            else
            begin
                ok = !((now_w > to) && (now_w < from));
            end
            return ok;
        end
    endfunction

endpackage

// ===== sv/gas_supply_valve_controller.sv =====
`timescale 1ns / 1ps
// Gas supply valve controller top level: input register, coil decision logic and result register.
// It depends on gsvc_pkg.
// A tick passes the input register, then the result register, which holds it on a stall.
// Throughput is one tick per cycle unless the output stalls; the relief flags update as each tick
// leaves the input register. Reset is asynchronous and active low; it clears the valid bits,
// relief flags and configuration registers.
module gas_supply_valve_controller
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // From bit 0: tank_pressure, vaporizer_pressure, liquid_level, time_of_day,
    // boot_inputs, sensor_error, heater_too_cold, zero fill.
    input  logic [gsvc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // From bit 0: valve_coils, mode, zero fill.
    output logic [gsvc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                 cfg_we,
    input  logic [gsvc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gsvc_pkg::CFG_W-1:0]           cfg_data
);

    logic [gsvc_pkg::CFG_W-1:0]   start_relief_reg;
    logic [gsvc_pkg::CFG_W-1:0]   vap_feed_reg;
    logic [gsvc_pkg::PRESS_W-1:0] tank_suppl_reg;
    logic [gsvc_pkg::CFG_W-1:0]   back_press_reg;
    logic [gsvc_pkg::CFG_W-1:0]   stop_tank_reg;
    logic [gsvc_pkg::CFG_W-1:0]   stop_vap_reg;
    logic [gsvc_pkg::CFG_W-1:0]   safety_reg;
    logic [gsvc_pkg::CFG_W-1:0]   time_window_reg;

    logic                         in_valid_reg;
    gsvc_pkg::tick_t              in_data_reg;
    logic                         out_valid_reg;
    logic [gsvc_pkg::COIL_W-1:0]  coils_reg;
    logic [gsvc_pkg::MODE_W-1:0]  mode_reg;

    logic                         start_relief_active_reg;
    logic                         stop_tank_relief_active_reg;
    logic                         stop_vap_relief_active_reg;

    logic                         start_relief_active_next;
    logic                         stop_tank_relief_active_next;
    logic                         stop_vap_relief_active_next;
    logic [gsvc_pkg::COIL_W-1:0]  coils_next;
    logic [gsvc_pkg::MODE_W-1:0]  mode_next;

    logic                         out_free;
    logic                         advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(gsvc_pkg::OUT_DATA_W - gsvc_pkg::COIL_W - gsvc_pkg::MODE_W){1'b0}},
                            mode_reg, coils_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_relief_reg <= '0;
            vap_feed_reg     <= '0;
            tank_suppl_reg   <= '0;
            back_press_reg   <= '0;
            stop_tank_reg    <= '0;
            stop_vap_reg     <= '0;
            safety_reg       <= '0;
            time_window_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gsvc_pkg::REG_START_RELIEF: start_relief_reg <= cfg_data;
                gsvc_pkg::REG_VAP_FEED:     vap_feed_reg     <= cfg_data;
                gsvc_pkg::REG_TANK_SUPPL:   tank_suppl_reg   <= cfg_data[gsvc_pkg::PRESS_W-1:0];
                gsvc_pkg::REG_BACK_PRESS:   back_press_reg   <= cfg_data;
                gsvc_pkg::REG_STOP_TANK:    stop_tank_reg    <= cfg_data;
                gsvc_pkg::REG_STOP_VAP:     stop_vap_reg     <= cfg_data;
                gsvc_pkg::REG_SAFETY:       safety_reg       <= cfg_data;
                gsvc_pkg::REG_TIME_WINDOW:  time_window_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        logic [gsvc_pkg::PRESS_W-1:0]     tank;
        logic [gsvc_pkg::PRESS_W-1:0]     vap;
        logic                             fault;
        logic                             force_stop;
        logic                             sra_set;
        logic                             sta_set;
        logic                             sva_set;

        tank = in_data_reg.tank_pressure;
        vap  = in_data_reg.vaporizer_pressure;

        start_relief_active_next     = start_relief_active_reg;
        stop_tank_relief_active_next = stop_tank_relief_active_reg;
        stop_vap_relief_active_next  = stop_vap_relief_active_reg;
        coils_next                   = '0;
        mode_next                    = gsvc_pkg::MODE_OFF;

        fault = in_data_reg.sensor_error
             || (tank < safety_reg[31:16])
             || (in_data_reg.liquid_level < safety_reg[15:0]);
        force_stop = in_data_reg.heater_too_cold
                  || !gsvc_pkg::in_window(in_data_reg.time_of_day,
                                          time_window_reg[31:16], time_window_reg[15:0])
                  || (in_data_reg.boot_inputs == '0);

        sra_set = (tank > start_relief_reg[31:16]) ? 1'b1 : start_relief_active_reg;
        sta_set = (tank > stop_tank_reg[31:16]) ? 1'b1 : stop_tank_relief_active_reg;
        sva_set = (vap > stop_vap_reg[31:16]) ? 1'b1 : stop_vap_relief_active_reg;

        priority if (fault)
        begin
            mode_next = gsvc_pkg::MODE_OFF;
        end
        else if (force_stop)
        begin
            mode_next                    = gsvc_pkg::MODE_STOP;
            start_relief_active_next     = 1'b0;
            stop_tank_relief_active_next = (tank < stop_tank_reg[15:0]) ? 1'b0 : sta_set;
            stop_vap_relief_active_next  = (vap < stop_vap_reg[15:0]) ? 1'b0 : sva_set;
            coils_next[gsvc_pkg::COIL_GAS] = (tank < back_press_reg[31:16])
                                          && (vap > back_press_reg[15:0]);
            coils_next[gsvc_pkg::COIL_RELIEF] = stop_tank_relief_active_next;
            coils_next[gsvc_pkg::COIL_OUTLET] = stop_vap_relief_active_next;
            coils_next[gsvc_pkg::COIL_USER0]  = stop_vap_relief_active_next;
        end
        else
        begin
            mode_next                = gsvc_pkg::MODE_START;
            start_relief_active_next = (tank < start_relief_reg[15:0]) ? 1'b0 : sra_set;
            coils_next[gsvc_pkg::COIL_W-1:gsvc_pkg::COIL_USER0] = in_data_reg.boot_inputs;
            coils_next[gsvc_pkg::COIL_OUTLET] = (vap > vap_feed_reg[31:16]);
            if (start_relief_active_next)
            begin
                coils_next[gsvc_pkg::COIL_GAS] = 1'b1;
            end
            else
            begin
                stop_tank_relief_active_next = 1'b0;
                stop_vap_relief_active_next  = 1'b0;
                if (vap > vap_feed_reg[15:0])
                begin
                    coils_next[gsvc_pkg::COIL_LIQUID] = 1'b1;
                end
                else
                begin
                    coils_next[gsvc_pkg::COIL_GAS] = (tank > tank_suppl_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg                <= 1'b0;
            out_valid_reg               <= 1'b0;
            start_relief_active_reg     <= 1'b0;
            stop_tank_relief_active_reg <= 1'b0;
            stop_vap_relief_active_reg  <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                start_relief_active_reg     <= start_relief_active_next;
                stop_tank_relief_active_reg <= stop_tank_relief_active_next;
                stop_vap_relief_active_reg  <= stop_vap_relief_active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= gsvc_pkg::tick_t'(s_axis_tdata[$bits(gsvc_pkg::tick_t)-1:0]);
        end
        if (advance)
        begin
            coils_reg <= coils_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

// ===== dv/valve_checker.sv =====
`timescale 1ns / 1ps
// Checker for the gas supply valve controller: follows register writes and input ticks,
// predicts the coil and mode result of each tick and compares it with the output stream.
// It depends on gsvc_pkg.
module valve_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [gsvc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [gsvc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [gsvc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gsvc_pkg::CFG_W-1:0]         cfg_data,
    output int                                 error_count,
    output int                                 results_owed
);
    import gsvc_pkg::*;

    localparam int NUM_LEVEL_REGS  = 8;
    localparam int NUM_LEVEL_SLOTS = 2 ** CFG_IDX_W;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic [MODE_W-1:0] mode;
    } valve_outcome_t;

    valve_outcome_t   owed_q[$];
    logic [CFG_W-1:0] levels [NUM_LEVEL_SLOTS];
    logic             start_relief_on;
    logic             tank_relief_on;
    logic             vap_relief_on;

    function automatic logic window_open(
        input logic [PRESS_W-1:0] now,
        input logic [PRESS_W-1:0] from,
        input logic [PRESS_W-1:0] till
    );
        begin
            if (from == till)
            begin
                return 1'b1;
            end
            if (from < till)
            begin
                return (now >= from) && (now <= till);
            end
            return !((now > till) && (now < from));
        end
    endfunction

    function automatic logic [COIL_W-1:0] start_coils(
        input logic [PRESS_W-1:0] tank,
        input logic [PRESS_W-1:0] vap
    );
        logic [COIL_W-1:0] c;
        begin
            c = '0;
            if (vap > levels[REG_VAP_FEED][31:16])
            begin
                c[COIL_OUTLET] = 1'b1;
            end
            if (tank > levels[REG_START_RELIEF][31:16])
            begin
                start_relief_on = 1'b1;
            end
            if (tank < levels[REG_START_RELIEF][15:0])
            begin
                start_relief_on = 1'b0;
            end
            if (start_relief_on)
            begin
                c[COIL_GAS] = 1'b1;
            end
            else
            begin
                if (vap > levels[REG_VAP_FEED][15:0])
                begin
                    c[COIL_LIQUID] = 1'b1;
                end
                else if (tank > levels[REG_TANK_SUPPL][15:0])
                begin
                    c[COIL_GAS] = 1'b1;
                end
                tank_relief_on = 1'b0;
                vap_relief_on  = 1'b0;
            end
            return c;
        end
    endfunction

    function automatic logic [COIL_W-1:0] stop_coils(
        input logic [PRESS_W-1:0] tank,
        input logic [PRESS_W-1:0] vap
    );
        logic [COIL_W-1:0] c;
        begin
            c = '0;
            start_relief_on = 1'b0;
            if (tank < levels[REG_BACK_PRESS][31:16] && vap > levels[REG_BACK_PRESS][15:0])
            begin
                c[COIL_GAS] = 1'b1;
            end
            if (tank > levels[REG_STOP_TANK][31:16])
            begin
                tank_relief_on = 1'b1;
            end
            if (tank < levels[REG_STOP_TANK][15:0])
            begin
                tank_relief_on = 1'b0;
            end
            if (tank_relief_on)
            begin
                c[COIL_RELIEF] = 1'b1;
            end
            if (vap > levels[REG_STOP_VAP][31:16])
            begin
                vap_relief_on = 1'b1;
            end
            if (vap < levels[REG_STOP_VAP][15:0])
            begin
                vap_relief_on = 1'b0;
            end
            if (vap_relief_on)
            begin
                c[COIL_OUTLET] = 1'b1;
                c[COIL_USER0]  = 1'b1;
            end
            return c;
        end
    endfunction

    function automatic valve_outcome_t next_outcome(input logic [IN_DATA_W-1:0] d);
        logic [PRESS_W-1:0]     tank;
        logic [PRESS_W-1:0]     vap;
        logic [PRESS_W-1:0]     lvl;
        logic [PRESS_W-1:0]     now;
        logic [USER_VALVES-1:0] boot;
        logic                   sensor_bad;
        logic                   cold;
        valve_outcome_t         r;
        begin
            tank       = d[15:0];
            vap        = d[31:16];
            lvl        = d[47:32];
            now        = PRESS_W'(d[60:48]);
            boot       = d[72:61];
            sensor_bad = d[73];
            cold       = d[74];
            r.coils    = '0;
            r.mode     = MODE_OFF;
            if (!(sensor_bad || tank < levels[REG_SAFETY][31:16]
                  || lvl < levels[REG_SAFETY][15:0]))
            begin
                if (cold || boot == '0 || !window_open(now, levels[REG_TIME_WINDOW][31:16],
                                                       levels[REG_TIME_WINDOW][15:0]))
                begin
                    r.coils = stop_coils(tank, vap);
                    r.mode  = MODE_STOP;
                end
                else
                begin
                    r.coils = start_coils(tank, vap);
                    r.coils[COIL_W-1:COIL_USER0] = boot;
                    r.mode  = MODE_START;
                end
            end
            return r;
        end
    endfunction

    initial
    begin
        error_count  = 0;
        results_owed = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        valve_outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVEL_SLOTS; i++)
            begin
                levels[i] = '0;
            end
            start_relief_on = 1'b0;
            tank_relief_on  = 1'b0;
            vap_relief_on   = 1'b0;
            owed_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (owed_q.size() == 0)
                begin
                    $error("valve result %h with no tick waiting", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (m_axis_tdata[COIL_W-1:0] !== want.coils)
                    begin
                        $error("valve_coils: expected %h, got %h",
                               want.coils, m_axis_tdata[COIL_W-1:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[COIL_W+MODE_W-1:COIL_W] !== want.mode)
                    begin
                        $error("mode: expected %0d, got %0d",
                               want.mode, m_axis_tdata[COIL_W+MODE_W-1:COIL_W]);
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                owed_q.push_back(next_outcome(s_axis_tdata));
            end
            if (cfg_we && cfg_index < NUM_LEVEL_REGS)
            begin
                if (cfg_index == REG_TANK_SUPPL)
                begin
                    levels[cfg_index] = {16'h0000, cfg_data[15:0]};
                end
                else
                begin
                    levels[cfg_index] = cfg_data;
                end
            end
        end
        results_owed = owed_q.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the valve controller testbench: clock, reset, register setup and tick stimulus
// under several idling patterns, with the verdict. It depends on gsvc_pkg, valve_checker
// and gas_supply_valve_controller.
module testbench;
    import gsvc_pkg::*;

    localparam int QUIET_LIMIT    = 2000;
    localparam int TICKS_PER_PASS = 90;
    localparam int NUM_PASSES     = 8;

    typedef struct packed {
        logic [4:0]             fill;
        logic                   heater_too_cold;
        logic                   sensor_error;
        logic [USER_VALVES-1:0] boot_inputs;
        logic [TIME_W-1:0]      time_of_day;
        logic [PRESS_W-1:0]     liquid_level;
        logic [PRESS_W-1:0]     vaporizer_pressure;
        logic [PRESS_W-1:0]     tank_pressure;
    } tick_fields_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;
    int                      error_count;
    int                      results_owed;
    logic                    tick_taken = 1'b0;
    int                      quiet_cycles = 0;
    int                      send_idle_pct = 0;
    int                      rx_stall_pct = 0;
    int                      tank_walk = 30000;
    int                      vap_walk = 15000;
    logic [CFG_W-1:0]        plan [2 ** CFG_IDX_W];
    tick_fields_t            t;

    always #10 clk = ~clk;

    gas_supply_valve_controller DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    valve_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .results_owed  (results_owed)
    );

    always @(posedge clk)
    begin
        tick_taken <= s_axis_tvalid && s_axis_tready;
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_tick(input tick_fields_t f);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_axis_tdata  <= f;
            s_axis_tvalid <= 1'b1;
            do
                @(negedge clk);
            while (!tick_taken);
        end
    endtask

    task automatic drain();
        begin
            s_axis_tvalid <= 1'b0;
            while (results_owed != 0)
            begin
                @(negedge clk);
            end
            repeat (4) @(negedge clk);
        end
    endtask

    // Writes the planned register values, then a write to an unused index.
    task automatic load_plan();
        begin
            for (int i = 0; i < 8; i++)
            begin
                cfg_we    <= 1'b1;
                cfg_index <= CFG_IDX_W'(i);
                cfg_data  <= plan[i];
                @(negedge clk);
            end
            cfg_index <= CFG_IDX_W'($urandom_range(15, 8));
            cfg_data  <= $urandom();
            @(negedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    function automatic tick_fields_t make_tick(
        input int tank, input int vap, input int lvl, input int tod,
        input int boot, input bit sensor_bad, input bit cold
    );
        tick_fields_t f;
        begin
            f                    = '0;
            f.tank_pressure      = tank[15:0];
            f.vaporizer_pressure = vap[15:0];
            f.liquid_level       = lvl[15:0];
            f.time_of_day        = tod[12:0];
            f.boot_inputs        = boot[11:0];
            f.sensor_error       = sensor_bad;
            f.heater_too_cold    = cold;
            return f;
        end
    endfunction

    function automatic logic [CFG_W-1:0] random_band();
        logic [15:0] a;
        logic [15:0] b;
        begin
            a = $urandom_range(65535);
            b = $urandom_range(65535);
            if ($urandom_range(7) == 0 || a > b)
            begin
                return {a, b};
            end
            return {b, a};
        end
    endfunction

    function automatic int clock_code();
        begin
            if ($urandom_range(3) == 0)
            begin
                return $urandom_range(5947);
            end
            return ($urandom_range(23) << 8) | $urandom_range(59);
        end
    endfunction

    function automatic int walk(input int v);
        int n;
        begin
            if ($urandom_range(15) == 0)
            begin
                return $urandom_range(65535);
            end
            n = v + $urandom_range(8000) - 4000;
            if (n < 0)
            begin
                n = 0;
            end
            if (n > 65535)
            begin
                n = 65535;
            end
            return n;
        end
    endfunction

    function automatic tick_fields_t random_tick();
        int boot;
        int pick;
        int lvl;
        begin
            tank_walk = walk(tank_walk);
            vap_walk  = walk(vap_walk);
            pick = $urandom_range(7);
            if (pick < 2)
            begin
                boot = 0;
            end
            else if (pick == 2)
            begin
                boot = 1 << $urandom_range(11);
            end
            else
            begin
                boot = $urandom_range(4095);
            end
            lvl = ($urandom_range(9) == 0) ? $urandom_range(4000) : $urandom_range(65535);
            return make_tick(tank_walk, vap_walk, lvl, clock_code(), boot,
                             $urandom_range(19) == 0, $urandom_range(9) == 0);
        end
    endfunction

    task automatic plan_typical();
        begin
            plan[REG_START_RELIEF] = {16'd40000, 16'd30000};
            plan[REG_VAP_FEED]     = {16'd20000, 16'd10000};
            plan[REG_TANK_SUPPL]   = {16'hBEEF, 16'd25000};
            plan[REG_BACK_PRESS]   = {16'd35000, 16'd5000};
            plan[REG_STOP_TANK]    = {16'd45000, 16'd38000};
            plan[REG_STOP_VAP]     = {16'd30000, 16'd22000};
            plan[REG_SAFETY]       = {16'd2000, 16'd1000};
            plan[REG_TIME_WINDOW]  = {16'h0600, 16'h1600};
        end
    endtask

    task automatic plan_random();
        int from;
        begin
            plan[REG_START_RELIEF] = random_band();
            plan[REG_VAP_FEED]     = random_band();
            plan[REG_TANK_SUPPL]   = $urandom();
            plan[REG_BACK_PRESS]   = random_band();
            plan[REG_STOP_TANK]    = random_band();
            plan[REG_STOP_VAP]     = random_band();
            plan[REG_SAFETY]       = {16'($urandom_range(4000)), 16'($urandom_range(4000))};
            from = clock_code();
            plan[REG_TIME_WINDOW]  = {16'(from),
                                      16'(($urandom_range(4) == 0) ? from : clock_code())};
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Registers still at reset: the window is always open and no safety limit applies.
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0));
        send_tick(make_tick(65535, 65535, 65535, 5947, 4095, 0, 0));
        send_tick(make_tick(1234, 4321, 99, 8'h1E, 12'hA5A, 1, 0));
        drain();

        plan_typical();
        load_plan();
        send_tick(make_tick(50000, 25000, 5000, 16'h0C00, 12'hFFF, 0, 0));
        send_tick(make_tick(35000, 15000, 5000, 16'h0C1E, 12'h001, 0, 0));
        send_tick(make_tick(20000, 15000, 5000, 16'h0D00, 12'h800, 0, 0));
        send_tick(make_tick(28000, 5000, 5000, 16'h0D10, 12'h0A5, 0, 0));
        send_tick(make_tick(10000, 5000, 5000, 16'h0E00, 12'h05A, 0, 0));
        send_tick(make_tick(50000, 25000, 5000, 16'h0E00, 12'hFFF, 1, 0));
        send_tick(make_tick(1000, 25000, 5000, 16'h0E00, 12'hFFF, 0, 0));
        send_tick(make_tick(50000, 25000, 500, 16'h0E00, 12'hFFF, 0, 0));
        send_tick(make_tick(50000, 35000, 5000, 16'h0E00, 12'hFFF, 0, 1));
        send_tick(make_tick(40000, 25000, 5000, 16'h0300, 12'h3C3, 0, 0));
        send_tick(make_tick(30000, 10000, 5000, 16'h0900, 12'h000, 0, 0));
        send_tick(make_tick(36000, 6000, 5000, 16'h0600, 12'h001, 0, 0));
        send_tick(make_tick(36000, 6000, 5000, 16'h1600, 12'h800, 0, 0));
        send_tick(make_tick(36000, 6000, 5000, 5947, 12'hFFF, 0, 0));
        send_tick(make_tick(36000, 6000, 5000, 16'h0800, 12'h555, 0, 1));
        send_tick(make_tick(65535, 65535, 65535, 16'h0F3B, 12'hFFF, 0, 1));
        send_tick(make_tick(0, 0, 0, 16'h0F3B, 12'hFFF, 0, 0));
        drain();

        for (int p = 0; p < NUM_PASSES; p++)
        begin
            case (p)
                0: plan_typical();
                1:
                begin
                    plan_random();
                    plan[REG_TIME_WINDOW] = {16'h1600, 16'h0600};
                end
                6:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        plan[i] = '0;
                    end
                end
                7:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        plan[i] = '1;
                    end
                end
                default: plan_random();
            endcase
            load_plan();
            send_idle_pct = (p % 4 == 1) ? 48 : (p % 4 == 3) ? 8 : 0;
            rx_stall_pct  = (p % 4 == 2) ? 48 : (p % 4 == 3) ? 8 : 0;
            for (int i = 0; i < TICKS_PER_PASS; i++)
            begin
                if (p == 2 && i == TICKS_PER_PASS / 2)
                begin
                    drain();
                end
                t = random_tick();
                send_tick(t);
            end
            drain();
        end

        repeat (10) @(negedge clk);
        if (error_count == 0 && results_owed == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== gas_supply_valve_controller.f =====
sv/gsvc_pkg.sv
sv/gas_supply_valve_controller.sv
dv/valve_checker.sv
dv/testbench.sv
